// ===== design/bpa_pkg.sv =====
// Package for the bitmap page allocator: codes, defaults, state type and
// the control/status bundles shared by controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

	localparam int MAP_PAGES_DEF  = 32768;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam logic [31:0] RESET_BASE  = 32'h4000_0000;
	localparam logic [31:0] RESET_START = 32'h4000_0000;

	// command codes
	localparam logic [2:0] CMD_ALLOC   = 3'd0;
	localparam logic [2:0] CMD_FREE    = 3'd1;
	localparam logic [2:0] CMD_RESERVE = 3'd2;
	localparam logic [2:0] CMD_MARK    = 3'd3;
	localparam logic [2:0] CMD_QUERY   = 3'd4;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_OOM      = 3'd1;
	localparam logic [2:0] STAT_NULL     = 3'd2;
	localparam logic [2:0] STAT_MISALIGN = 3'd3;
	localparam logic [2:0] STAT_RANGE    = 3'd4;
	localparam logic [2:0] STAT_DBLFREE  = 3'd5;

	// configuration register indexes
	localparam logic REG_REGION_BASE   = 1'b0;
	localparam logic REG_RESERVE_START = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LOAD,
		ST_EXEC,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic init;
		logic check;
		logic rd;
		logic load;
		logic exec;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic pre_done;
		logic ex_finish;
		logic ex_next;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/bpa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== design/bpa_ctrl.sv =====
// Controller state machine for the bitmap page allocator.
// Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire bpa_pkg::stat_t stat,
	output bpa_pkg::ctl_t      ctl,
	output logic               busy,
	output logic               done
);

	bpa_pkg::state_t state_q, state_nx;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		ctl      = '0;
		busy     = 1'b1;
		done     = 1'b0;
		case (state_q)
			bpa_pkg::ST_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_nx = bpa_pkg::ST_IDLE;
				end
			end
			bpa_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.init = 1'b1;
					state_nx = bpa_pkg::ST_CHECK;
				end
			end
			bpa_pkg::ST_CHECK: begin
				ctl.check = 1'b1;
				state_nx  = stat.pre_done ? bpa_pkg::ST_DONE : bpa_pkg::ST_READ;
			end
			bpa_pkg::ST_READ: begin
				ctl.rd   = 1'b1;
				state_nx = bpa_pkg::ST_LOAD;
			end
			bpa_pkg::ST_LOAD: begin
				ctl.load = 1'b1;
				state_nx = bpa_pkg::ST_EXEC;
			end
			bpa_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.ex_finish) begin
					state_nx = bpa_pkg::ST_DONE;
				end else if (stat.ex_next) begin
					state_nx = bpa_pkg::ST_READ;
				end
			end
			bpa_pkg::ST_DONE: begin
				done     = 1'b1;
				state_nx = bpa_pkg::ST_IDLE;
			end
			default: begin
				state_nx = bpa_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/bpa_datapath.sv =====
// Datapath for the bitmap page allocator: configuration, counters, range
// checks, word scan logic and the bitmap RAM. Depends on bpa_pkg, bpa_ram.
`timescale 1ns / 1ps
`default_nettype none
module bpa_datapath #(
	parameter int MAP_PAGES  = bpa_pkg::MAP_PAGES_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire bpa_pkg::ctl_t  ctl,
	output bpa_pkg::stat_t      stat,
	input  wire logic           cfg_valid,
	input  wire logic           cfg_index,
	input  wire logic [31:0]    cfg_data,
	input  wire logic [2:0]     command,
	input  wire logic [31:0]    address,
	input  wire logic [15:0]    page_count,
	output logic      [2:0]     status,
	output logic      [31:0]    page_address,
	output logic      [15:0]    reserved_count,
	output logic                page_used,
	output logic      [15:0]    current_pages,
	output logic      [15:0]    peak_pages,
	output logic      [31:0]    total_allocs,
	output logic      [31:0]    failed_allocs
);

	localparam int PS    = $clog2(PAGE_BYTES);
	localparam int WORDS = (MAP_PAGES + 31) / 32;
	localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int NW    = $clog2(MAP_PAGES + 1);

	logic [31:0]    base_q, rstart_q;
	logic [2:0]     cmd_q;
	logic [31:0]    addr_q;
	logic [15:0]    want_q;
	logic [WAW-1:0] widx_q;
	logic [4:0]     bo_q;
	logic [NW-1:0]  p0_q;
	logic [15:0]    rem_q;
	logic [31:0]    word_q;
	logic [15:0]    cur_q, peak_q;
	logic [31:0]    total_q, failed_q;
	logic [2:0]     res_status_q;
	logic [31:0]    res_addr_q;
	logic [15:0]    res_cnt_q;
	logic           res_used_q;
	logic           clr_last_x, pre_done_x, ex_finish_x, ex_next_x;

	// managed page count for the current base
	logic [32:0] room, n33, off33, pfull, roff33, rpfull;
	logic        in_rng, rs_ge, rsv_empty;
	logic [WAW-1:0] lw;

	always_comb begin
		room   = (33'h1_0000_0000 - {1'b0, base_q}) >> PS;
		n33    = (room < 33'(MAP_PAGES)) ? room : 33'(MAP_PAGES);
		lw     = WAW'((n33 - 33'd1) >> 5);
		off33  = {1'b0, addr_q - base_q};
		pfull  = off33 >> PS;
		in_rng = (addr_q >= base_q) && (pfull < n33);
		roff33 = {1'b0, rstart_q - base_q};
		rpfull = roff33 >> PS;
		rs_ge  = (rstart_q >= base_q);
		rsv_empty = (n33 == 33'd0) || (want_q == 16'd0) || (rs_ge && (rpfull >= n33));
	end

	// early completion without a bitmap access
	always_comb begin
		case (cmd_q)
			bpa_pkg::CMD_ALLOC:   pre_done_x = (n33 == 33'd0);
			bpa_pkg::CMD_FREE:    pre_done_x = (addr_q == 32'd0) ||
				(addr_q[PS-1:0] != '0) || !in_rng;
			bpa_pkg::CMD_RESERVE: pre_done_x = rsv_empty;
			bpa_pkg::CMD_MARK:    pre_done_x = !in_rng;
			bpa_pkg::CMD_QUERY:   pre_done_x = !in_rng;
			default:              pre_done_x = 1'b1;
		endcase
	end

	assign clr_last_x = (widx_q == WAW'(WORDS - 1));

	// status bundle to the controller
	assign stat = {clr_last_x, pre_done_x, ex_finish_x, ex_next_x};

	// per-bit eligibility within the current word
	logic [31:0] elig_a, elig_r, cand_a, cand_r, iso;
	logic [32:0] pg33;
	logic [4:0]  lo;
	logic [5:0]  pop;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			pg33      = 33'({widx_q, 5'(i)});
			elig_a[i] = (pg33 < n33);
			elig_r[i] = elig_a[i] && (pg33 >= 33'(p0_q));
		end
		pg33   = 33'({widx_q, 5'd0});
		cand_a = ~word_q & elig_a;
		cand_r = ~word_q & elig_r;
		iso    = cand_r & (~cand_r + 32'd1);
		pop    = 6'($countones(cand_r));
		lo     = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (cand_a[i]) begin
				lo = 5'(i);
			end
		end
	end

	// word step decision and write-back data
	logic        mem_we_x, take_all, stay;
	logic [31:0] wdata_x;
	logic [31:0] onehot_bo, onehot_lo;

	always_comb begin
		onehot_bo   = 32'd1 << bo_q;
		onehot_lo   = 32'd1 << lo;
		ex_finish_x = 1'b0;
		ex_next_x   = 1'b0;
		mem_we_x    = 1'b0;
		wdata_x     = word_q;
		take_all    = ({10'd0, pop} <= rem_q);
		stay        = 1'b0;
		case (cmd_q)
			bpa_pkg::CMD_ALLOC: begin
				if (cand_a != 32'd0) begin
					mem_we_x    = 1'b1;
					wdata_x     = word_q | onehot_lo;
					ex_finish_x = 1'b1;
				end else if (widx_q == lw) begin
					ex_finish_x = 1'b1;
				end else begin
					ex_next_x = 1'b1;
				end
			end
			bpa_pkg::CMD_FREE: begin
				ex_finish_x = 1'b1;
				if (word_q[bo_q]) begin
					mem_we_x = 1'b1;
					wdata_x  = word_q & ~onehot_bo;
				end
			end
			bpa_pkg::CMD_MARK: begin
				ex_finish_x = 1'b1;
				mem_we_x    = 1'b1;
				wdata_x     = word_q | onehot_bo;
			end
			bpa_pkg::CMD_RESERVE: begin
				if (take_all) begin
					mem_we_x = 1'b1;
					wdata_x  = word_q | cand_r;
					if ((rem_q == {10'd0, pop}) || (widx_q == lw)) begin
						ex_finish_x = 1'b1;
					end else begin
						ex_next_x = 1'b1;
					end
				end else if (rem_q == 16'd0) begin
					mem_we_x    = 1'b1;
					ex_finish_x = 1'b1;
				end else begin
					stay = 1'b1;
				end
			end
			default: begin
				ex_finish_x = 1'b1;
			end
		endcase
	end

	// bitmap RAM: clearing sweep or write-back
	logic           ram_we;
	logic [31:0]    ram_wdata, ram_rdata;

	assign ram_we    = ctl.clr_step || (ctl.exec && mem_we_x);
	assign ram_wdata = ctl.clr_step ? 32'd0 : wdata_x;

	bpa_ram #(
		.WIDTH(32),
		.DEPTH(WORDS)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(widx_q),
		.wdata(ram_wdata),
		.re   (ctl.rd),
		.raddr(widx_q),
		.rdata(ram_rdata)
	);

	// configuration transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= bpa_pkg::RESET_BASE;
			rstart_q <= bpa_pkg::RESET_START;
		end else if (cfg_valid) begin
			if (cfg_index == bpa_pkg::REG_REGION_BASE) begin
				base_q <= cfg_data;
			end else begin
				rstart_q <= cfg_data;
			end
		end
	end

	// next counter values on a successful allocation
	logic [15:0] cur_inc;
	assign cur_inc = (cur_q == 16'hFFFF) ? cur_q : cur_q + 16'd1;

	// word index: clearing sweep, start word and scan advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
		end else if (ctl.clr_step) begin
			widx_q <= stat.clr_last ? '0 : widx_q + WAW'(1);
		end else if (ctl.check) begin
			case (cmd_q)
				bpa_pkg::CMD_ALLOC:   widx_q <= '0;
				bpa_pkg::CMD_RESERVE: widx_q <= rs_ge ? WAW'(rpfull >> 5) : '0;
				default:              widx_q <= WAW'(pfull >> 5);
			endcase
		end else if (ctl.exec && stat.ex_next) begin
			widx_q <= widx_q + WAW'(1);
		end
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q    <= '0;
			peak_q   <= '0;
			total_q  <= '0;
			failed_q <= '0;
		end else if (ctl.check && stat.pre_done && cmd_q == bpa_pkg::CMD_ALLOC) begin
			failed_q <= failed_q + 32'd1;
		end else if (ctl.exec && stat.ex_finish) begin
			if (cmd_q == bpa_pkg::CMD_ALLOC) begin
				if (cand_a != 32'd0) begin
					total_q <= total_q + 32'd1;
					cur_q   <= cur_inc;
					if (cur_inc > peak_q) begin
						peak_q <= cur_inc;
					end
				end else begin
					failed_q <= failed_q + 32'd1;
				end
			end else if (cmd_q == bpa_pkg::CMD_FREE && word_q[bo_q] && cur_q != 16'd0) begin
				cur_q <= cur_q - 16'd1;
			end
		end
	end

	// command latch, word buffer and per-command results
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			cmd_q        <= command;
			addr_q       <= address;
			want_q       <= page_count;
			res_status_q <= bpa_pkg::STAT_OK;
			res_addr_q   <= '0;
			res_cnt_q    <= '0;
			res_used_q   <= 1'b0;
		end
		if (ctl.check) begin
			bo_q  <= pfull[4:0];
			p0_q  <= rs_ge ? NW'(rpfull) : '0;
			rem_q <= want_q;
			case (cmd_q)
				bpa_pkg::CMD_ALLOC: begin
					if (stat.pre_done) begin
						res_status_q <= bpa_pkg::STAT_OOM;
					end
				end
				bpa_pkg::CMD_FREE: begin
					if (addr_q == 32'd0) begin
						res_status_q <= bpa_pkg::STAT_NULL;
					end else if (addr_q[PS-1:0] != '0) begin
						res_status_q <= bpa_pkg::STAT_MISALIGN;
					end else if (!in_rng) begin
						res_status_q <= bpa_pkg::STAT_RANGE;
					end
				end
				bpa_pkg::CMD_MARK: begin
					if (!in_rng) begin
						res_status_q <= bpa_pkg::STAT_RANGE;
					end
				end
				bpa_pkg::CMD_QUERY: begin
					if (!in_rng) begin
						res_used_q <= 1'b1;
					end
				end
				default: begin
					res_status_q <= res_status_q;
				end
			endcase
		end
		if (ctl.load) begin
			word_q <= ram_rdata;
		end
		if (ctl.exec) begin
			case (cmd_q)
				bpa_pkg::CMD_ALLOC: begin
					if (cand_a != 32'd0) begin
						res_addr_q <= base_q + 32'(33'({widx_q, lo}) << PS);
					end else if (stat.ex_finish) begin
						res_status_q <= bpa_pkg::STAT_OOM;
					end
				end
				bpa_pkg::CMD_FREE: begin
					if (!word_q[bo_q]) begin
						res_status_q <= bpa_pkg::STAT_DBLFREE;
					end
				end
				bpa_pkg::CMD_QUERY: begin
					res_used_q <= word_q[bo_q];
				end
				bpa_pkg::CMD_RESERVE: begin
					if (stay) begin
						word_q    <= word_q | iso;
						rem_q     <= rem_q - 16'd1;
						res_cnt_q <= res_cnt_q + 16'd1;
					end else if (take_all) begin
						rem_q     <= rem_q - {10'd0, pop};
						res_cnt_q <= res_cnt_q + {10'd0, pop};
					end
				end
				default: begin
					res_used_q <= res_used_q;
				end
			endcase
		end
	end

	assign status         = res_status_q;
	assign page_address   = res_addr_q;
	assign reserved_count = res_cnt_q;
	assign page_used      = res_used_q;
	assign current_pages  = cur_q;
	assign peak_pages     = peak_q;
	assign total_allocs   = total_q;
	assign failed_allocs  = failed_q;

endmodule
`default_nettype wire

// ===== design/bitmap_page_allocator_core.sv =====
// Top level of the bitmap page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_datapath (which holds bpa_ram).
//
// Usage:
//  - Commands: drive command, address and page_count with start high; the
//    command transfers on a rising edge with start high and busy low.
//  - Results: one result per command, shown for exactly one cycle with done
//    high; the receiver takes it then and cannot hold it off.
//  - Configuration: cfg_valid with cfg_index (0 region base, 1 reserve
//    start) and cfg_data; cfg_ready is always high. Write only while idle.
//  - Steps: a bitmap word of 32 pages passes through read, load and
//    evaluate via the single bitmap RAM. Free, mark and query visit one
//    word, or none when they fail early. Alloc scans words until a free
//    page is found, up to ceil(MAP_PAGES/32) words. Reserve takes one page
//    at a time in a word that holds more free pages than are still wanted.
//  - Reset: the map is cleared by a sweep over all ceil(MAP_PAGES/32) words
//    (1024 at the default size); busy stays high until it ends.
//  - The next command can transfer in the cycle after done.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_allocator_core #(
	parameter int MAP_PAGES  = bpa_pkg::MAP_PAGES_DEF,
	parameter int PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [31:0] address,
	input  wire logic [15:0] page_count,
	output logic             done,
	output logic      [2:0]  status,
	output logic      [31:0] page_address,
	output logic      [15:0] reserved_count,
	output logic             page_used,
	output logic      [15:0] current_pages,
	output logic      [15:0] peak_pages,
	output logic      [31:0] total_allocs,
	output logic      [31:0] failed_allocs,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);

	bpa_pkg::ctl_t  ctl;
	bpa_pkg::stat_t stat;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.ctl   (ctl),
		.busy  (busy),
		.done  (done)
	);

	bpa_datapath #(
		.MAP_PAGES (MAP_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.command       (command),
		.address       (address),
		.page_count    (page_count),
		.status        (status),
		.page_address  (page_address),
		.reserved_count(reserved_count),
		.page_used     (page_used),
		.current_pages (current_pages),
		.peak_pages    (peak_pages),
		.total_allocs  (total_allocs),
		.failed_allocs (failed_allocs)
	);

endmodule
`default_nettype wire
